@@ design/mlp_pkg.sv @@
// Package for the perceptron trainer: sizes, codes, fixed-point helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package mlp_pkg;
    localparam int NUM_FEATURES = 3;
    localparam int NUM_HIDDEN   = 6;
    localparam int FRAC_BITS    = 16;
    localparam int NW           = NUM_HIDDEN * NUM_FEATURES;
    localparam int CNT_W        = 4;
    localparam int FEAT_W       = $clog2(NUM_FEATURES);

    localparam logic [1:0] MODE_PREDICT = 2'd0;
    localparam logic [1:0] MODE_TRAIN   = 2'd1;
    localparam logic [1:0] MODE_LOAD    = 2'd2;

    localparam logic [16:0] RATE_RESET  = 17'd655;
    localparam logic [16:0] SLOPE_RESET = 17'd655;

    localparam logic ADDR_RATE  = 1'b0;
    localparam logic ADDR_SLOPE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_HID, ST_ACT, ST_OUT, ST_ERR, ST_GRAD, ST_LEAK, ST_RATE, ST_UPD,
        ST_DONE
    } state_t;

    // Control from the sequencer to the cells.
    typedef struct packed {
        logic              load;
        logic [4:0]        slot;
        logic              hid;
        logic              first;
        logic [FEAT_W-1:0] feat;
        logic              act;
        logic              grad;
        logic              leak;
        logic              rate;
        logic              upd;
    } cell_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) sat32 = 32'sh7fffffff;
        else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] q;
        p = a * b;
        q = p >>> FRAC_BITS;
        if (q > 64'sd2147483647) fmul = 32'sh7fffffff;
        else if (q < -64'sd2147483648) fmul = 32'sh80000000;
        else fmul = q[31:0];
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        sadd = sat32(34'(a) + 34'(b));
    endfunction

    function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        ssub = sat32(34'(a) - 34'(b));
    endfunction
endpackage

@@ design/mlp_cell.sv @@
// One hidden unit: its weights, bias, output weight, and its own MAC.
// Depends on mlp_pkg.
`timescale 1ns / 1ps
module mlp_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [4:0]            cell_idx,
    input  mlp_pkg::cell_ctl_t    ctl,
    input  logic signed [31:0]    param_data,
    input  logic signed [31:0]    x_a,
    input  logic signed [31:0]    x_b,
    input  logic signed [31:0]    x_c,
    input  logic [16:0]           leak_slope,
    input  logic [16:0]           learn_rate,
    input  logic signed [31:0]    d_in,
    input  logic signed [31:0]    g_in,
    input  logic signed [31:0]    acc_in,
    output logic signed [31:0]    acc_out
);
    import mlp_pkg::*;

    logic signed [31:0] w_reg [NUM_FEATURES];
    logic signed [31:0] b_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] z_reg;
    logic signed [31:0] h_reg;
    logic signed [31:0] e_reg;
    logic signed [31:0] gi_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] z_next;
    logic signed [31:0] mac_w;
    logic signed [31:0] slope_s;
    logic signed [31:0] rate_s;
    logic signed [31:0] xs [NUM_FEATURES];
    logic [4:0] base;

    assign base = 5'(cell_idx * NUM_FEATURES);

    always_comb
    begin
        for (int j = 0; j < NUM_FEATURES; j++)
        begin
            xs[j] = (j == 0) ? x_a : (j == 1) ? x_b : (j == 2) ? x_c : 32'sd0;
        end
        slope_s = $signed({15'd0, leak_slope});
        rate_s  = $signed({15'd0, learn_rate});
        // One feature per cycle; the first step starts from the bias.
        mac_w  = fmul(w_reg[ctl.feat], xs[ctl.feat]);
        z_next = sadd(ctl.first ? b_reg : z_reg, mac_w);
    end

    // The output sum moves one cell down the row every cycle.
    assign acc_out = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_FEATURES; j++) w_reg[j] <= '0;
            b_reg <= '0;
            v_reg <= '0;
        end
        else if (ctl.load)
        begin
            for (int j = 0; j < NUM_FEATURES; j++)
            begin
                if (ctl.slot == 5'(base + 5'(j))) w_reg[j] <= param_data;
            end
            if (ctl.slot == 5'(NW + cell_idx)) b_reg <= param_data;
            if (ctl.slot == 5'(NW + NUM_HIDDEN + cell_idx)) v_reg <= param_data;
        end
        else if (ctl.upd)
        begin
            for (int j = 0; j < NUM_FEATURES; j++)
                w_reg[j] <= ssub(w_reg[j], fmul(gi_reg, xs[j]));
            b_reg <= ssub(b_reg, gi_reg);
            v_reg <= ssub(v_reg, fmul(g_in, h_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.hid) z_reg <= z_next;
        if (ctl.act) h_reg <= (z_reg > 0) ? z_reg : fmul(slope_s, z_reg);
        if (ctl.grad) e_reg <= fmul(d_in, v_reg);
        else if (ctl.leak && z_reg <= 0) e_reg <= fmul(e_reg, slope_s);
        if (ctl.rate) gi_reg <= fmul(rate_s, e_reg);
        acc_reg <= sadd(acc_in, fmul(v_reg, h_reg));
    end
endmodule

@@ design/mlp_sgd_train_step_top.sv @@
// Top level of the perceptron trainer: sequencer, row of hidden cells, APB.
// Depends on mlp_pkg and mlp_cell.
//
//  channel   dir  contents
//  s_axis    in   tdata: mode, feature_a, feature_b, feature_c, goal_value, param_slot, param_data
//  m_axis    out  tdata: prediction, pred_error
//  apb       in   learn_rate at 0x0, leak_slope at 0x4
//
// For predict and train the result follows the feature steps, the activation,
// the output sum walking the row and the error; train then adds the gradient,
// leak, rate and update steps, and load writes its one parameter slot. The next
// input is taken only when idle with no result held, so each item finishes before
// the next starts. Reset clears the weights and biases to zero; learn_rate and
// leak_slope reset to 655. A held result blocks new input.
`timescale 1ns / 1ps
module mlp_sgd_train_step_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[1:0], feature_a[33:2], feature_b[65:34], feature_c[97:66],
    // goal_value[129:98], param_slot[134:130], param_data[166:135]
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // prediction[31:0], pred_error[63:32]
    output logic [63:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mlp_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0] rate_reg, slope_reg;
    logic [1:0]  mode_reg;
    logic signed [31:0] xa_reg, xb_reg, xc_reg, goal_reg, pdata_reg;
    logic [4:0] slot_reg;
    logic signed [31:0] ob_reg, pred_reg, err_reg, d_reg, g_reg;
    logic signed [31:0] chain [NUM_HIDDEN+1];
    logic signed [31:0] err_w, d_w, g_w;
    logic out_valid_reg;
    cell_ctl_t ctl;
    logic take;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_SLOPE) ? {15'd0, slope_reg} : {15'd0, rate_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= RATE_RESET;
            slope_reg <= SLOPE_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == ADDR_RATE) rate_reg <= pwdata[16:0];
            else slope_reg <= pwdata[16:0];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign take = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg + CNT_W'(1);
        ctl = '0;
        ctl.slot = slot_reg;
        ctl.feat = FEAT_W'(cnt_reg);
        ctl.first = (cnt_reg == '0);
        case (state_reg)
            ST_IDLE: if (take) state_next = ST_HID;
            ST_HID:
            begin
                if (mode_reg == MODE_LOAD)
                begin
                    ctl.load = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    ctl.hid = 1'b1;
                    if (cnt_reg == CNT_W'(NUM_FEATURES - 1)) state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                ctl.act = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: if (cnt_reg == CNT_W'(NUM_HIDDEN - 1)) state_next = ST_ERR;
            ST_ERR: state_next = (mode_reg == MODE_TRAIN) ? ST_GRAD : ST_DONE;
            ST_GRAD:
            begin
                ctl.grad = 1'b1;
                state_next = ST_LEAK;
            end
            ST_LEAK:
            begin
                ctl.leak = 1'b1;
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                ctl.rate = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ctl.upd = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (state_next != state_reg) cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mode_reg  <= s_axis_tdata[1:0];
            xa_reg    <= s_axis_tdata[33:2];
            xb_reg    <= s_axis_tdata[65:34];
            xc_reg    <= s_axis_tdata[97:66];
            goal_reg  <= s_axis_tdata[129:98];
            slot_reg  <= s_axis_tdata[134:130];
            pdata_reg <= s_axis_tdata[166:135];
        end
    end

    assign chain[0] = ob_reg;
    genvar gi;
    generate
        for (gi = 0; gi < NUM_HIDDEN; gi++)
        begin : g_cell
            mlp_cell u_cell (
                .clk(clk), .rst_n(rst_n), .cell_idx(5'(gi)), .ctl(ctl),
                .param_data(pdata_reg), .x_a(xa_reg), .x_b(xb_reg), .x_c(xc_reg),
                .leak_slope(slope_reg), .learn_rate(rate_reg), .d_in(d_reg),
                .g_in(g_reg), .acc_in(chain[gi]), .acc_out(chain[gi+1])
            );
        end
    endgenerate

    assign err_w = ssub(chain[NUM_HIDDEN], goal_reg);
    assign d_w   = sat32(34'(2) * (34'(chain[NUM_HIDDEN]) - 34'(goal_reg)));
    assign g_w   = fmul($signed({15'd0, rate_reg}), d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load && slot_reg == 5'(NW + 2 * NUM_HIDDEN)) ob_reg <= pdata_reg;
            else if (ctl.upd) ob_reg <= ssub(ob_reg, g_reg);
            if (state_reg == ST_DONE) out_valid_reg <= 1'b1;
            else if (m_axis_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ERR)
        begin
            pred_reg <= chain[NUM_HIDDEN];
            err_reg  <= err_w;
            d_reg    <= d_w;
        end
        else if (state_reg == ST_HID && mode_reg == MODE_LOAD)
        begin
            pred_reg <= '0;
            err_reg  <= '0;
        end
        if (state_reg == ST_GRAD) g_reg <= g_w;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {err_reg, pred_reg};

    assert property (@(posedge clk) disable iff (!rst_n) take |=> state_reg == ST_HID)
        else $error("accepted item did not start");
    assert property (@(posedge clk) disable iff (!rst_n) m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result held");
    assert property (@(posedge clk) disable iff (!rst_n) !(ctl.load && ctl.upd))
        else $error("load and update together");
endmodule

@@ sim/mlp_sgd_train_step_top_test.sv @@
// Testbench for the perceptron trainer: drives items over the input stream,
// predicts each prediction/error pair in place, and checks the output stream.
// Depends on mlp_pkg and mlp_sgd_train_step_top.
`timescale 1ns / 1ps
module mlp_sgd_train_step_top_test;
    import mlp_pkg::*;

    typedef struct packed {
        logic signed [31:0] param_data;
        logic [4:0]         param_slot;
        logic signed [31:0] goal_value;
        logic signed [31:0] feature_c;
        logic signed [31:0] feature_b;
        logic signed [31:0] feature_a;
        logic [1:0]         mode;
    } net_item_t;

    typedef struct packed {
        logic signed [31:0] pred_error;
        logic signed [31:0] prediction;
    } net_result_t;

    localparam int CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    mlp_sgd_train_step_top dut (.*);

    // Predictor copy of the network and its registers.
    logic signed [31:0] hw_mdl [NW];
    logic signed [31:0] hb_mdl [NUM_HIDDEN];
    logic signed [31:0] ow_mdl [NUM_HIDDEN];
    logic signed [31:0] ob_mdl;
    logic [16:0]        rate_mdl;
    logic [16:0]        slope_mdl;

    net_item_t   pending_items [$];
    net_result_t expected_outputs [$];
    bit          had_failure;
    bit          stim_done;
    int          cycle_count;
    int          burst_left;
    int          gap_left;
    int          hold_off_left;
    int          stall_phase;
    bit          long_hold_req;

    function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Fixed-point product; >>> on a signed value floors toward minus infinity.
    function automatic logic signed [31:0] qmul(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return clamp32(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return clamp32(66'(a) + 66'(b));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return clamp32(66'(a) - 66'(b));
    endfunction

    function automatic net_result_t run_network(input net_item_t it);
        logic signed [31:0] x [NUM_FEATURES];
        logic signed [31:0] z [NUM_HIDDEN];
        logic signed [31:0] h [NUM_HIDDEN];
        logic signed [31:0] e [NUM_HIDDEN];
        logic signed [31:0] acc, pred, d, g, gi;
        logic signed [33:0] rate_s, slope_s;
        net_result_t r;
        r = '0;
        rate_s = 34'(rate_mdl);
        slope_s = 34'(slope_mdl);
        if (it.mode == MODE_LOAD) begin
            if (it.param_slot < NW) hw_mdl[it.param_slot] = it.param_data;
            else if (it.param_slot < NW + NUM_HIDDEN)
                hb_mdl[it.param_slot - NW] = it.param_data;
            else if (it.param_slot < NW + 2 * NUM_HIDDEN)
                ow_mdl[it.param_slot - NW - NUM_HIDDEN] = it.param_data;
            else if (it.param_slot == NW + 2 * NUM_HIDDEN) ob_mdl = it.param_data;
            return r;
        end
        x[0] = it.feature_a;
        x[1] = it.feature_b;
        x[2] = it.feature_c;
        pred = ob_mdl;
        for (int i = 0; i < NUM_HIDDEN; i++) begin
            acc = hb_mdl[i];
            for (int j = 0; j < NUM_FEATURES; j++)
                acc = qadd(acc, qmul(hw_mdl[i * NUM_FEATURES + j], x[j]));
            z[i] = acc;
            h[i] = (acc > 0) ? acc : qmul(slope_s, acc);
            pred = qadd(pred, qmul(ow_mdl[i], h[i]));
        end
        r.prediction = pred;
        r.pred_error = qsub(pred, it.goal_value);
        if (it.mode == MODE_TRAIN) begin
            d = clamp32(2 * (66'(pred) - 66'(it.goal_value)));
            for (int i = 0; i < NUM_HIDDEN; i++) begin
                e[i] = qmul(d, ow_mdl[i]);
                if (z[i] <= 0) e[i] = qmul(e[i], slope_s);
            end
            g = qmul(rate_s, d);
            for (int i = 0; i < NUM_HIDDEN; i++)
                ow_mdl[i] = qsub(ow_mdl[i], qmul(g, h[i]));
            ob_mdl = qsub(ob_mdl, g);
            for (int i = 0; i < NUM_HIDDEN; i++) begin
                gi = qmul(rate_s, e[i]);
                for (int j = 0; j < NUM_FEATURES; j++)
                    hw_mdl[i * NUM_FEATURES + j] =
                        qsub(hw_mdl[i * NUM_FEATURES + j], qmul(gi, x[j]));
                hb_mdl[i] = qsub(hb_mdl[i], gi);
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
        endcase
    endfunction

    function automatic net_item_t rand_item(input logic [1:0] mode);
        net_item_t it;
        it.mode = mode;
        it.feature_a = rand_word();
        it.feature_b = rand_word();
        it.feature_c = rand_word();
        it.goal_value = rand_word();
        it.param_slot = 5'($urandom_range(0, 31));
        it.param_data = rand_word();
        return it;
    endfunction

    function automatic net_item_t load_item(input int slot, input logic [31:0] v);
        net_item_t it;
        it = rand_item(MODE_LOAD);
        it.param_slot = 5'(slot);
        it.param_data = v;
        return it;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stream driver: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_outputs.push_back(run_network(net_item_t'(s_axis_tdata[166:0])));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0 || pending_items.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, pending_items.pop_front()};
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_phase   <= 0;
            hold_off_left <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (long_hold_req && hold_off_left == 0 && stall_phase >= 0)
                hold_off_left <= 300;
            if (hold_off_left > 1)
            begin
                hold_off_left <= hold_off_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (hold_off_left == 1) hold_off_left <= -1;
                if ((stall_phase / 256) % 2 == 0) m_axis_tready <= 1'b1;
                else m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                net_result_t act, exp_r;
                act = m_axis_tdata;
                if (expected_outputs.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %h", $time, act);
                    had_failure = 1'b1;
                end
                else
                begin
                    exp_r = expected_outputs.pop_front();
                    if (act.prediction !== exp_r.prediction)
                    begin
                        $display("%0t: prediction expected %h actual %h",
                                 $time, exp_r.prediction, act.prediction);
                        had_failure = 1'b1;
                    end
                    if (act.pred_error !== exp_r.pred_error)
                    begin
                        $display("%0t: pred_error expected %h actual %h",
                                 $time, exp_r.pred_error, act.pred_error);
                        had_failure = 1'b1;
                    end
                end
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'(4 * ADDR_RATE)) rate_mdl = data[16:0];
        else slope_mdl = data[16:0];
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic load_all_params();
        for (int s = 0; s <= NW + 2 * NUM_HIDDEN; s++)
            pending_items.push_back(load_item(s,
                32'($signed($urandom_range(0, 2 << 16)) - (1 << 16))));
    endtask

    initial
    begin
        int mode_pick;
        had_failure = 1'b0;
        stim_done = 1'b0;
        long_hold_req = 1'b0;
        cycle_count = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < NW; i++) hw_mdl[i] = '0;
        for (int i = 0; i < NUM_HIDDEN; i++)
        begin
            hb_mdl[i] = '0;
            ow_mdl[i] = '0;
        end
        ob_mdl = '0;
        rate_mdl = RATE_RESET;
        slope_mdl = SLOPE_RESET;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero network, extremes, every slot, unused mode and bad slot.
        pending_items.push_back(rand_item(MODE_PREDICT));
        load_all_params();
        pending_items.push_back(load_item(31, 32'h7fffffff));
        pending_items.push_back(load_item(NW + 2 * NUM_HIDDEN, 32'h7fffffff));
        begin
            net_item_t it;
            it = rand_item(MODE_TRAIN);
            it.feature_a = 32'h80000000;
            it.feature_b = 32'h7fffffff;
            it.feature_c = 32'hffffffff;
            it.goal_value = 32'h80000000;
            pending_items.push_back(it);
            it.mode = 2'd3;
            pending_items.push_back(it);
        end
        drain();

        // Random phases across register settings, extremes included.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin reg_write(3'(4 * ADDR_RATE), 32'd0); reg_write(3'(4 * ADDR_SLOPE), 32'd65536); end
                1: begin reg_write(3'(4 * ADDR_RATE), 32'd65536); reg_write(3'(4 * ADDR_SLOPE), 32'd0); end
                2: begin reg_write(3'(4 * ADDR_RATE), 32'hfffe0000 | 32'd655); reg_write(3'(4 * ADDR_SLOPE), 32'd655); end
                default: begin reg_write(3'(4 * ADDR_RATE), $urandom_range(0, 3000));
                    reg_write(3'(4 * ADDR_SLOPE), $urandom_range(0, 65536)); end
            endcase
            load_all_params();
            if (phase == 3) long_hold_req = 1'b1;
            for (int n = 0; n < 150; n++)
            begin
                mode_pick = $urandom_range(0, 19);
                if (mode_pick < 9) pending_items.push_back(rand_item(MODE_TRAIN));
                else if (mode_pick < 15) pending_items.push_back(rand_item(MODE_PREDICT));
                else if (mode_pick < 18) pending_items.push_back(rand_item(MODE_LOAD));
                else pending_items.push_back(rand_item(2'd3));
            end
            drain();
            long_hold_req = 1'b0;
        end
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done === 1'b1 || cycle_count >= CYCLE_LIMIT);
        if (stim_done !== 1'b1)
        begin
            $display("Test completed with failures");
        end
        else if (!had_failure)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
